[hw/rtl/cidr_pkg.sv]
// ---------------------------------------------------------------------------
// cidr_pkg: shared constants for the ipv4 prefix parser
// status codes, character codes and field widths used by the rtl and its
// channel interfaces
// ---------------------------------------------------------------------------
package cidr_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned PLEN_W   = 6;

    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [PLEN_W-1:0]   t_plen;

    // status codes, first failure in text order wins
    localparam t_status ST_OK          = 4'd0;
    localparam t_status ST_BAD_CHAR    = 4'd1;
    localparam t_status ST_EMPTY_OCTET = 4'd2;
    localparam t_status ST_OCTET_RANGE = 4'd3;
    localparam t_status ST_OCTET_COUNT = 4'd4;
    localparam t_status ST_NO_SLASH    = 4'd5;
    localparam t_status ST_LEN_TEXT    = 4'd6;
    localparam t_status ST_LEN_RANGE   = 4'd7;
    localparam t_status ST_HOST_BITS   = 4'd8;

    // ascii codes
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_SLASH = 8'h2F;

    // limits
    localparam logic [8:0] OCTET_MAX    = 9'd255;
    localparam logic [8:0] OCTET_SAT    = 9'd256;
    localparam logic [2:0] OCTETS_NEED  = 3'd4;
    localparam logic [2:0] OCTETS_SAT   = 3'd5;
    localparam logic [6:0] LEN_MAX      = 7'd32;
    localparam logic [6:0] LEN_SAT      = 7'd100;
    localparam logic [1:0] LEN_DIG_SAT  = 2'd3;

endpackage

[hw/rtl/cidr_if.sv]
// ---------------------------------------------------------------------------
// cidr_if: valid/ready channels of the ipv4 prefix parser
// character beats in, parse results out
// ---------------------------------------------------------------------------
interface cidr_char_if
    import cidr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_char char_code;
    logic  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cidr_result_if
    import cidr_pkg::*;
;
    logic    valid;
    logic    ready;
    t_status status;
    t_addr   network_address;
    t_plen   prefix_length;
    t_addr   netmask;

    modport source (output valid, output status, output network_address,
                    output prefix_length, output netmask, input ready);
    modport sink   (input valid, input status, input network_address,
                    input prefix_length, input netmask, output ready);
endinterface

[hw/rtl/ipv4_cidr_prefix_parser.sv]
// ---------------------------------------------------------------------------
// ipv4_cidr_prefix_parser: streaming a.b.c.d/n text parser
// one ascii character per beat in, one result beat per text out
// ---------------------------------------------------------------------------
// usage
// - i_in carries the prefix text one character per beat; last_char marks
//   the final character of a text, after which parsing starts fresh
// - o_out gives one beat per text: status, network address, prefix length
//   and netmask; on any failure the three values are zero and status holds
//   the first failure in text order
// - throughput is one character per cycle while i_in.ready is high; the
//   parse state is updated in each cycle a character is taken, the result
//   register only in the cycle the final character is taken, and the
//   result beat is valid the cycle after the final character is accepted
// - the result register is a single output stage; while it holds a beat
//   that the receiver has not taken, i_in.ready drops, so a stalled
//   receiver stalls the character stream (and ready follows o_out.ready
//   combinationally while the stage is full)
// - reset (synchronous, active low) clears the parse state and drops the
//   result beat; the first character after reset starts a new text
// ---------------------------------------------------------------------------
module ipv4_cidr_prefix_parser
    import cidr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cidr_char_if.sink     i_in,
    cidr_result_if.source o_out
);

    // parse state
    logic       r_in_length;
    t_addr      r_addr;
    logic [8:0] r_octet_val;
    logic       r_octet_dig;
    logic [2:0] r_octet_cnt;
    logic [6:0] r_len_val;
    logic [1:0] r_len_dig;
    t_status    r_err;

    logic       n_in_length;
    t_addr      n_addr;
    logic [8:0] n_octet_val;
    logic       n_octet_dig;
    logic [2:0] n_octet_cnt;
    logic [6:0] n_len_val;
    logic [1:0] n_len_dig;
    t_status    n_err;

    // result stage
    logic    r_out_valid;
    t_status r_status;
    t_addr   r_net_addr;
    t_plen   r_plen;
    t_addr   r_mask;

    t_status n_status;
    t_addr   n_net_addr;
    t_plen   n_plen;
    t_addr   n_mask;

    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [12:0] octet_prod;
    logic [10:0] len_prod;
    logic [5:0]  shift_amt;
    t_addr       mask;

    // output stage free or being emptied this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign is_digit   = (i_in.char_code >= CH_ZERO) && (i_in.char_code <= CH_NINE);
    assign digit      = i_in.char_code[3:0];
    assign octet_prod = {4'b0, r_octet_val} * 13'd10 + {9'b0, digit};
    assign len_prod   = {4'b0, r_len_val} * 11'd10 + {7'b0, digit};

    // character step
    always_comb begin
        n_in_length = r_in_length;
        n_addr      = r_addr;
        n_octet_val = r_octet_val;
        n_octet_dig = r_octet_dig;
        n_octet_cnt = r_octet_cnt;
        n_len_val   = r_len_val;
        n_len_dig   = r_len_dig;
        n_err       = r_err;

        if (!r_in_length) begin
            if (is_digit) begin
                n_octet_val = (octet_prod > {4'b0, OCTET_SAT}) ? OCTET_SAT
                                                                : octet_prod[8:0];
                n_octet_dig = 1'b1;
            end else if (i_in.char_code == CH_DOT || i_in.char_code == CH_SLASH) begin
                // close the octet in progress
                if (!r_octet_dig) begin
                    if (n_err == ST_OK) n_err = ST_EMPTY_OCTET;
                end else begin
                    if (r_octet_val > OCTET_MAX && n_err == ST_OK) n_err = ST_OCTET_RANGE;
                    n_addr      = {r_addr[ADDR_W-9:0], r_octet_val[7:0]};
                    n_octet_cnt = (r_octet_cnt < OCTETS_SAT) ? r_octet_cnt + 3'd1
                                                             : r_octet_cnt;
                    n_octet_val = '0;
                    n_octet_dig = 1'b0;
                    if (i_in.char_code == CH_SLASH && n_octet_cnt != OCTETS_NEED
                        && n_err == ST_OK) begin
                        n_err = ST_OCTET_COUNT;
                    end
                end
                if (i_in.char_code == CH_SLASH) n_in_length = 1'b1;
            end else begin
                if (n_err == ST_OK) n_err = ST_BAD_CHAR;
            end
        end else begin
            if (is_digit) begin
                // leading zero followed by more digits
                if (r_len_dig != 2'd0 && r_len_val == 7'd0 && n_err == ST_OK) begin
                    n_err = ST_LEN_TEXT;
                end
                n_len_val = (len_prod > {4'b0, LEN_SAT}) ? LEN_SAT : len_prod[6:0];
                n_len_dig = (r_len_dig < LEN_DIG_SAT) ? r_len_dig + 2'd1 : r_len_dig;
            end else begin
                if (n_err == ST_OK) n_err = ST_LEN_TEXT;
            end
        end
    end

    // end-of-text checks; mask is only used when the length is in range,
    // and a shift by the full width gives the all-zero mask of length zero
    assign shift_amt = 6'd32 - n_len_val[5:0];
    assign mask      = {ADDR_W{1'b1}} << shift_amt;

    always_comb begin
        n_status = n_err;
        if (!n_in_length) begin
            if (n_status == ST_OK) n_status = ST_NO_SLASH;
        end else if (n_len_dig == 2'd0) begin
            if (n_status == ST_OK) n_status = ST_LEN_TEXT;
        end else if (n_len_val > LEN_MAX) begin
            if (n_status == ST_OK) n_status = ST_LEN_RANGE;
        end else begin
            if ((n_addr & ~mask) != '0 && n_status == ST_OK) n_status = ST_HOST_BITS;
        end

        if (n_status == ST_OK) begin
            n_net_addr = n_addr;
            n_plen     = n_len_val[5:0];
            n_mask     = mask;
        end else begin
            n_net_addr = '0;
            n_plen     = '0;
            n_mask     = '0;
        end
    end

    // parse state: cleared by reset and after each final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.last_char)) begin
            r_in_length <= 1'b0;
            r_addr      <= '0;
            r_octet_val <= '0;
            r_octet_dig <= 1'b0;
            r_octet_cnt <= '0;
            r_len_val   <= '0;
            r_len_dig   <= '0;
            r_err       <= ST_OK;
        end else if (accept) begin
            r_in_length <= n_in_length;
            r_addr      <= n_addr;
            r_octet_val <= n_octet_val;
            r_octet_dig <= n_octet_dig;
            r_octet_cnt <= n_octet_cnt;
            r_len_val   <= n_len_val;
            r_len_dig   <= n_len_dig;
            r_err       <= n_err;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in.last_char) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.last_char) begin
            r_status   <= n_status;
            r_net_addr <= n_net_addr;
            r_plen     <= n_plen;
            r_mask     <= n_mask;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.network_address = r_net_addr;
    assign o_out.prefix_length   = r_plen;
    assign o_out.netmask         = r_mask;

    // a result beat only follows a final character
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(accept && i_in.last_char))
        else $error("result beat without a final character");

    // failed parses carry zero values
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |->
            (r_net_addr == '0 && r_plen == '0 && r_mask == '0))
        else $error("nonzero values on failed parse");

    // good parses: length in range and no host bits
    a_ok_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OK) |->
            (r_plen <= 6'd32 && (r_net_addr & ~r_mask) == '0))
        else $error("inconsistent good result");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status <= ST_HOST_BITS))
        else $error("status code out of range");

    // state is fresh after a final character
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last_char) |=>
            (!r_in_length && r_err == ST_OK && r_octet_cnt == 3'd0 && !r_octet_dig))
        else $error("parse state not cleared after final character");

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb: testbench for the ipv4 prefix parser
// feeds prefix text one character per beat, predicts status, address,
// length and mask for every final character, and checks each result beat
// field by field; directed texts first, then random well-formed, broken and
// noisy texts, with random idle cycles on both channels
// ---------------------------------------------------------------------------
module tb;
    import cidr_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_CHARS = 850;
    localparam int IDLE_PCT     = 31;

    // one result beat
    typedef struct packed {
        t_status status;
        t_addr   addr;
        t_plen   plen;
        t_addr   mask;
    } t_prefix;

    // parser state as the predictor keeps it
    typedef struct packed {
        logic       in_len;
        t_addr      addr;
        logic [8:0] oct_val;
        logic       oct_seen;
        logic [2:0] oct_cnt;
        logic [6:0] len_val;
        logic [1:0] len_dig;
        t_status    err;
    } t_parse_state;

    // directed text: typed expectation where fixed is set, poke_at >= 0
    // overrides one character with a byte a string literal cannot carry
    typedef struct {
        string   text;
        bit      fixed;
        t_status st;
        t_addr   addr;
        t_plen   plen;
        t_addr   mask;
        int      poke_at;
        t_char   poke_val;
    } t_text_row;

    typedef t_char t_char_q[$];

    logic i_clk;
    logic i_rst_n;

    cidr_char_if   chr_if ();
    cidr_result_if res_if ();

    ipv4_cidr_prefix_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chr_if),
        .o_out   (res_if)
    );

    t_parse_state ps;
    t_prefix      prefix_q[$];   // predicted prefixes, oldest first
    t_prefix      want;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    bit           steady;        // no idling on either side while set

    // directed texts: extremes, every status code, first-failure ordering
    t_text_row dir_rows[26] = '{
        '{"0.0.0.0/0",          1'b1, ST_OK, 32'h0000_0000, 6'd0,  32'h0000_0000, -1, 8'h00},
        '{"255.255.255.255/32", 1'b1, ST_OK, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, -1, 8'h00},
        '{"10.1.0.0/16",        1'b1, ST_OK, 32'h0A01_0000, 6'd16, 32'hFFFF_0000, -1, 8'h00},
        '{"192.168.1.0/24",     1'b0, ST_OK, 32'h0,         6'd0,  32'h0,         -1, 8'h00},
        '{"00010.000.0.0/8",    1'b0, ST_OK, 32'h0,         6'd0,  32'h0,         -1, 8'h00},
        '{"1.2.3.5/31",         1'b1, ST_HOST_BITS,    32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.0.0.0/0",          1'b1, ST_HOST_BITS,    32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"256.0.0.0/8",        1'b1, ST_OCTET_RANGE,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"99999.0.0.0/8",      1'b1, ST_OCTET_RANGE,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.2.3/8",            1'b1, ST_OCTET_COUNT,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.2.3.4.5/8",        1'b1, ST_OCTET_COUNT,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1..2.3.4/8",         1'b1, ST_EMPTY_OCTET,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{".1.2.3/8",           1'b1, ST_EMPTY_OCTET,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.2.3./8",           1'b1, ST_EMPTY_OCTET,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"/",                  1'b1, ST_EMPTY_OCTET,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.2.3.4",            1'b1, ST_NO_SLASH,     32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1..2",               1'b1, ST_EMPTY_OCTET,  32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.2#3.4",            1'b1, ST_BAD_CHAR,     32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"?.0.0.0/8",          1'b1, ST_BAD_CHAR,     32'h0, 6'd0, 32'h0,  0, 8'h00},
        '{"1.2.?.4/8",          1'b1, ST_BAD_CHAR,     32'h0, 6'd0, 32'h0,  4, 8'hFF},
        '{"1.2.3.4/",           1'b1, ST_LEN_TEXT,     32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"0.0.0.0/00",         1'b1, ST_LEN_TEXT,     32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.2.3.4/08",         1'b1, ST_LEN_TEXT,     32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.0.0.0/8/",         1'b1, ST_LEN_TEXT,     32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"1.2.3.4/33",         1'b1, ST_LEN_RANGE,    32'h0, 6'd0, 32'h0, -1, 8'h00},
        '{"0.0.0.0/999",        1'b1, ST_LEN_RANGE,    32'h0, 6'd0, 32'h0, -1, 8'h00}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // keep only the first failure in text order
    function automatic void flag_error(input t_status code);
        if (ps.err == ST_OK)
            ps.err = code;
    endfunction

    // finish the octet in progress; an empty one is refused
    function automatic bit close_octet();
        if (!ps.oct_seen) begin
            flag_error(ST_EMPTY_OCTET);
            return 1'b0;
        end
        if (ps.oct_val > OCTET_MAX)
            flag_error(ST_OCTET_RANGE);
        ps.addr = {ps.addr[23:0], ps.oct_val[7:0]};
        if (ps.oct_cnt < OCTETS_SAT)
            ps.oct_cnt = ps.oct_cnt + 3'd1;
        ps.oct_val  = '0;
        ps.oct_seen = 1'b0;
        return 1'b1;
    endfunction

    // consume one character; returns 1 with the prefix on the final one
    function automatic bit scan_char(input t_char c, input logic last,
                                     output t_prefix res);
        int    v;
        bit    is_digit;
        t_addr mask;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        mask     = '0;
        res      = '0;
        if (!ps.in_len) begin
            if (is_digit) begin
                v = int'(ps.oct_val) * 10 + int'(c) - int'(CH_ZERO);
                ps.oct_val  = (v > int'(OCTET_SAT)) ? OCTET_SAT : v[8:0];
                ps.oct_seen = 1'b1;
            end else if (c == CH_DOT) begin
                void'(close_octet());
            end else if (c == CH_SLASH) begin
                if (close_octet() && ps.oct_cnt != OCTETS_NEED)
                    flag_error(ST_OCTET_COUNT);
                ps.in_len = 1'b1;
            end else begin
                flag_error(ST_BAD_CHAR);
            end
        end else begin
            if (is_digit) begin
                // a digit after a lone leading zero
                if (ps.len_dig != 0 && ps.len_val == 0)
                    flag_error(ST_LEN_TEXT);
                v = int'(ps.len_val) * 10 + int'(c) - int'(CH_ZERO);
                ps.len_val = (v > int'(LEN_SAT)) ? LEN_SAT : v[6:0];
                if (ps.len_dig < LEN_DIG_SAT)
                    ps.len_dig = ps.len_dig + 2'd1;
            end else begin
                flag_error(ST_LEN_TEXT);
            end
        end
        if (!last)
            return 1'b0;

        if (!ps.in_len) begin
            flag_error(ST_NO_SLASH);
        end else if (ps.len_dig == 0) begin
            flag_error(ST_LEN_TEXT);
        end else if (ps.len_val > LEN_MAX) begin
            flag_error(ST_LEN_RANGE);
        end else begin
            if (ps.len_val != 0)
                mask = ~t_addr'(0) << (LEN_MAX - ps.len_val);
            if ((ps.addr & mask) != ps.addr)
                flag_error(ST_HOST_BITS);
        end

        if (ps.err != ST_OK) begin
            res.status = ps.err;
        end else begin
            res.status = ST_OK;
            res.addr   = ps.addr;
            res.plen   = t_plen'(ps.len_val);
            res.mask   = mask;
        end
        ps = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // random text: mostly well-formed prefixes, some broken, some noise
    // ---------------------------------------------------------------------
    function automatic t_char noise_char();
        string pool;
        pool = "0123456789./";
        if ($urandom_range(1) == 0)
            return t_char'($urandom_range(255));
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic t_char_q make_prefix_text();
        t_char_q txt;
        string   s;
        t_addr   addr;
        t_addr   mask;
        int      plen;
        int      n_oct;
        int      pick;
        int      k;
        int      oct[5];
        plen = $urandom_range(32);
        addr = $urandom;
        mask = (plen == 0) ? '0 : ~t_addr'(0) << (32 - plen);
        // mostly clean host bits so that the ok path is reached
        if ($urandom_range(99) < 85)
            addr = addr & mask;
        for (k = 0; k < 4; k++)
            oct[k] = addr[31 - 8 * k -: 8];
        oct[4] = $urandom_range(255);
        if ($urandom_range(99) < 8)
            oct[$urandom_range(3)] = $urandom_range(999, 256);

        pick  = $urandom_range(99);
        n_oct = (pick < 4) ? 3 : (pick < 8) ? 5 : 4;
        s = "";
        for (k = 0; k < n_oct; k++) begin
            if (k != 0)
                s = {s, "."};
            if ($urandom_range(99) < 10)
                s = {s, $sformatf("%03d", oct[k])};
            else
                s = {s, $sformatf("%0d", oct[k])};
        end

        pick = $urandom_range(99);
        if (pick < 82)
            s = {s, $sformatf("/%0d", plen)};
        else if (pick < 86)
            s = {s, $sformatf("/0%0d", plen)};
        else if (pick < 92)
            s = {s, $sformatf("/%0d", $urandom_range(999, 33))};
        else if (pick < 96)
            s = {s, "/"};
        // else the slash is left out

        for (k = 0; k < s.len(); k++)
            txt.push_back(s[k]);

        // break some texts, replace a few with noise
        pick = $urandom_range(99);
        if (pick < 6) begin
            txt.delete();
            repeat ($urandom_range(16, 1))
                txt.push_back(noise_char());
        end else if (pick < 11) begin
            txt[$urandom_range(txt.size() - 1)] = t_char'($urandom_range(255));
        end else if (pick < 14) begin
            txt.delete($urandom_range(txt.size() - 1));
        end else if (pick < 17) begin
            txt.insert($urandom_range(txt.size()), noise_char());
        end
        if (txt.size() == 0)
            txt.push_back(noise_char());
        return txt;
    endfunction

    // ---------------------------------------------------------------------
    // character channel driver
    // ---------------------------------------------------------------------
    task automatic push_char(input t_char c, input logic last,
                             input bit fixed, input t_prefix fixed_res);
        t_prefix res;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            chr_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        chr_if.valid     <= 1'b1;
        chr_if.char_code <= c;
        chr_if.last_char <= last;
        @(posedge i_clk);
        while (!chr_if.ready)
            @(posedge i_clk);
        // beat taken at this edge
        if (scan_char(c, last, res))
            prefix_q.push_back(fixed ? fixed_res : res);
    endtask

    task automatic send_text(input t_char_q txt, input bit fixed,
                             input t_prefix fixed_res);
        int k;
        for (k = 0; k < txt.size(); k++)
            push_char(txt[k], k == txt.size() - 1, fixed, fixed_res);
    endtask

    // ---------------------------------------------------------------------
    // result channel: random backpressure, checking against predictions
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (prefix_q.size() == 0) begin
                $error("unexpected result beat: status %0d", res_if.status);
                mismatches++;
            end else begin
                want = prefix_q.pop_front();
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    mismatches++;
                end
                if (res_if.network_address !== want.addr) begin
                    $error("network_address: expected %h, got %h",
                           want.addr, res_if.network_address);
                    mismatches++;
                end
                if (res_if.prefix_length !== want.plen) begin
                    $error("prefix_length: expected %0d, got %0d",
                           want.plen, res_if.prefix_length);
                    mismatches++;
                end
                if (res_if.netmask !== want.mask) begin
                    $error("netmask: expected %h, got %h", want.mask, res_if.netmask);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // watchdog: any beat on either side restarts the count
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((chr_if.valid && chr_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("tb failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_char_q txt;
        t_prefix typed;
        int      r;
        int      k;
        int      text_idx;
        int      sent_chars;

        ps           = '0;
        steady       = 1'b0;
        text_idx     = 0;
        sent_chars   = 0;

        i_rst_n          <= 1'b0;
        chr_if.valid     <= 1'b0;
        chr_if.char_code <= '0;
        chr_if.last_char <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed texts
        for (r = 0; r < $size(dir_rows); r++) begin
            txt.delete();
            for (k = 0; k < dir_rows[r].text.len(); k++) begin
                if (k == dir_rows[r].poke_at)
                    txt.push_back(dir_rows[r].poke_val);
                else
                    txt.push_back(dir_rows[r].text[k]);
            end
            typed.status = dir_rows[r].st;
            typed.addr   = dir_rows[r].addr;
            typed.plen   = dir_rows[r].plen;
            typed.mask   = dir_rows[r].mask;
            send_text(txt, dir_rows[r].fixed, typed);
        end

        // random texts, with a stretch at full rate on both sides
        while (sent_chars < RANDOM_CHARS) begin
            steady = (text_idx >= 30) && (text_idx < 45);
            txt = make_prefix_text();
            send_text(txt, 1'b0, '0);
            sent_chars += txt.size();
            text_idx++;
        end
        steady = 1'b0;
        chr_if.valid <= 1'b0;

        // drain outstanding results, then a few quiet cycles
        while (prefix_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
